// ===== rtl/twda_pkg.sv =====
// shared types, constants and a helper function for the ternary weight dot accumulator
package twda_pkg;

   localparam int ACT_W       = 8;
   localparam int CODE_W      = 2;
   localparam int LANES       = 4;
   localparam int COUNT_W     = 3;
   localparam int TERM_W      = 10;
   localparam int SUM_W       = TERM_W + 1;
   localparam int OUT_W       = 21;
   localparam int ACC_WIDTH_DEF = 21;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(LANES);

   localparam logic signed [TERM_W-1:0] PAIR_MAX = TERM_W'(127);
   localparam logic signed [TERM_W-1:0] PAIR_MIN = TERM_W'(-128);

   // ternary weight codes, two and three both mean plus one
   localparam logic [CODE_W-1:0] CODE_NEG  = 2'd0;
   localparam logic [CODE_W-1:0] CODE_ZERO = 2'd1;

   // the one or two terms an item adds, in order, plus their sum
   typedef struct packed {
      logic signed [TERM_W-1:0] first;
      logic signed [TERM_W-1:0] second;
      logic signed [SUM_W-1:0]  both;
   } term_type;

   function automatic logic signed [ACT_W:0] weighted(input logic [CODE_W-1:0] code,
                                                      input logic signed [ACT_W-1:0] act);
      logic signed [ACT_W:0] ext;
      ext = {act[ACT_W-1], act};
      case (code)
         CODE_NEG:  weighted = -ext;
         CODE_ZERO: weighted = '0;
         default:   weighted = ext;
      endcase
   endfunction

endpackage

// ===== rtl/twda_term.sv =====
// decodes one item into the terms it adds to the accumulator, pair sums clipped when pair_clamp is set
module twda_term (
   input  logic [7:0]         weight_codes,
   input  logic signed [7:0]  act0,
   input  logic signed [7:0]  act1,
   input  logic signed [7:0]  act2,
   input  logic signed [7:0]  act3,
   input  logic [2:0]         valid_count,
   input  logic               pair_clamp,
   output twda_pkg::term_type terms
);
   import twda_pkg::*;

   logic signed [ACT_W-1:0]  act [LANES];
   logic signed [ACT_W:0]    wact [LANES];
   logic signed [TERM_W-1:0] pair_raw [2];
   logic signed [TERM_W-1:0] pair_sum [2];
   logic signed [TERM_W-1:0] odd_lo;
   logic signed [TERM_W-1:0] odd_hi;
   logic [COUNT_W-1:0]       count;

   assign act[0] = act0;
   assign act[1] = act1;
   assign act[2] = act2;
   assign act[3] = act3;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         wact[j] = weighted(weight_codes[CODE_W*j +: CODE_W], act[j]);
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         pair_raw[p] = {wact[2*p][ACT_W], wact[2*p]} + {wact[2*p+1][ACT_W], wact[2*p+1]};
         if (pair_clamp && (pair_raw[p] > PAIR_MAX)) begin
            pair_sum[p] = PAIR_MAX;
         end else if (pair_clamp && (pair_raw[p] < PAIR_MIN)) begin
            pair_sum[p] = PAIR_MIN;
         end else begin
            pair_sum[p] = pair_raw[p];
         end
      end
   end

   assign odd_lo = {wact[0][ACT_W], wact[0]};
   assign odd_hi = {wact[2][ACT_W], wact[2]};
   assign count  = (valid_count > MAX_COUNT) ? MAX_COUNT : valid_count;

   always_comb begin
      terms.first  = '0;
      terms.second = '0;
      case (count)
         3'd0: begin
         end
         3'd1: begin
            terms.first = odd_lo;
         end
         3'd2: begin
            terms.first = pair_sum[0];
         end
         3'd3: begin
            terms.first  = pair_sum[0];
            terms.second = odd_hi;
         end
         default: begin
            terms.first  = pair_sum[0];
            terms.second = pair_sum[1];
         end
      endcase
      terms.both = {terms.first[TERM_W-1], terms.first}
                 + {terms.second[TERM_W-1], terms.second};
   end

endmodule

// ===== rtl/twda_accum.sv =====
// saturating accumulator and the registered result stage
module twda_accum #(
   parameter int ACC_WIDTH = twda_pkg::ACC_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          stage_valid,
   input  logic                          stage_last,
   input  twda_pkg::term_type            stage_terms,
   output logic                          stage_taken,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [twda_pkg::OUT_W-1:0] rsp_total
);
   import twda_pkg::*;

   localparam logic signed [ACC_WIDTH:0] ACC_MAX = {2'b00, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH:0] ACC_MIN = {2'b11, {(ACC_WIDTH-1){1'b0}}};

   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]     total_ff, total_in;

   logic signed [ACC_WIDTH:0]   acc_ext, first_ext, second_ext, both_ext;
   logic signed [ACC_WIDTH:0]   sum_first, sum_both, hi_second, lo_second;
   logic signed [ACC_WIDTH-1:0] acc_sum;
   logic signed [ACC_WIDTH+OUT_W-1:0] acc_wide;

   assign acc_ext    = {acc_ff[ACC_WIDTH-1], acc_ff};
   assign first_ext  = {{(ACC_WIDTH+1-TERM_W){stage_terms.first[TERM_W-1]}}, stage_terms.first};
   assign second_ext = {{(ACC_WIDTH+1-TERM_W){stage_terms.second[TERM_W-1]}},
                        stage_terms.second};
   assign both_ext   = {{(ACC_WIDTH+1-SUM_W){stage_terms.both[SUM_W-1]}}, stage_terms.both};

   // both adds run side by side: the second term on its own only matters after a clip
   assign sum_first = acc_ext + first_ext;
   assign sum_both  = acc_ext + both_ext;
   assign hi_second = ACC_MAX + second_ext;
   assign lo_second = ACC_MIN + second_ext;

   always_comb begin
      if (sum_first > ACC_MAX) begin
         acc_sum = (second_ext[ACC_WIDTH] == 1'b0) ? ACC_MAX[ACC_WIDTH-1:0]
                                                   : hi_second[ACC_WIDTH-1:0];
      end else if (sum_first < ACC_MIN) begin
         acc_sum = (second_ext[ACC_WIDTH] == 1'b1) ? ACC_MIN[ACC_WIDTH-1:0]
                                                   : lo_second[ACC_WIDTH-1:0];
      end else if (sum_both > ACC_MAX) begin
         acc_sum = ACC_MAX[ACC_WIDTH-1:0];
      end else if (sum_both < ACC_MIN) begin
         acc_sum = ACC_MIN[ACC_WIDTH-1:0];
      end else begin
         acc_sum = sum_both[ACC_WIDTH-1:0];
      end
   end

   assign acc_wide    = {{OUT_W{acc_sum[ACC_WIDTH-1]}}, acc_sum};
   assign stage_taken = stage_valid && (!stage_last || !rsp_valid_ff || rsp_ready);

   always_comb begin
      acc_in       = acc_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (stage_taken) begin
         if (stage_last) begin
            acc_in       = '0;
            total_in     = acc_wide[OUT_W-1:0];
            rsp_valid_in = 1'b1;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff <= total_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_total = total_ff;

endmodule

// ===== rtl/ternary_weight_dot_accumulator_core.sv =====
// top level of the ternary weight int8 dot product accumulator
// Streams ternary-weight dot products: each item carries four 2-bit weight codes
// (0 is -1, 1 is 0, 2 and 3 are +1) and four signed int8 activations, of which
// the leading valid_count are used (0 uses none, above four counts as four).
// Weights 0/1 and 2/3 form pairs; with pair_clamp set each pair sum is clipped
// to int8 before it is added, a leftover single weight goes in unclipped, and
// the accumulator saturates at its ACC_WIDTH-bit signed range after every add.
// The item with tlast set returns the row total (sign extended or cut to 21 bits)
// and clears the accumulator. One item is taken every clock unless a last item
// waits on an untaken total: the weight decode and pair sums sit in front of
// the input register, the accumulator loop is one wide add and compare, and
// the result register lets the next row run while a total waits. pair_clamp
// resets to 1 and may be written only while no item is in flight.
module ternary_weight_dot_accumulator_core #(
   parameter int ACC_WIDTH = twda_pkg::ACC_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata from bit 0: weight_codes[7:0], act0, act1, act2, act3, valid_count[2:0], zero pad
   input  logic [twda_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata from bit 0: dot_total[20:0], zero pad
   output logic [twda_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pair_clamp register write
   input  logic                              csr_wdata,
   input  logic                              csr_valid,
   output logic                              csr_ready
);
   import twda_pkg::*;

   logic                    pair_clamp_ff, pair_clamp_in;
   logic                    stage_valid_ff, stage_valid_in;
   logic                    stage_last_ff, stage_last_in;
   term_type                stage_terms_ff, stage_terms_in;
   term_type                req_terms;
   logic                    stage_taken;
   logic                    req_take;
   logic signed [OUT_W-1:0] dot_total;

   // config register, always ready
   assign csr_ready     = 1'b1;
   assign pair_clamp_in = csr_valid ? csr_wdata : pair_clamp_ff;

   // decode the incoming item into its one or two accumulator terms
   twda_term u_term (
      .weight_codes (req_tdata[7:0]),
      .act0         (req_tdata[15:8]),
      .act1         (req_tdata[23:16]),
      .act2         (req_tdata[31:24]),
      .act3         (req_tdata[39:32]),
      .valid_count  (req_tdata[42:40]),
      .pair_clamp   (pair_clamp_ff),
      .terms        (req_terms)
   );

   // input stage refills in the same cycle it drains
   assign req_tready = !stage_valid_ff || stage_taken;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff && !stage_taken;
      stage_last_in  = stage_last_ff;
      stage_terms_in = stage_terms_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
         stage_last_in  = req_tlast;
         stage_terms_in = req_terms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_clamp_ff  <= 1'b1;
         stage_valid_ff <= 1'b0;
      end else begin
         pair_clamp_ff  <= pair_clamp_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_last_ff  <= stage_last_in;
      stage_terms_ff <= stage_terms_in;
   end

   // accumulator loop and result register
   twda_accum #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage_last  (stage_last_ff),
      .stage_terms (stage_terms_ff),
      .stage_taken (stage_taken),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_total   (dot_total)
   );

   assign rsp_tdata = {{(RSP_DATA_W-OUT_W){1'b0}}, dot_total};

endmodule
